[hdl/rtfp_pkg.sv]
package rtfp_pkg;

   // Sizes
   localparam int unsigned MAX_GROUP_DEPTH_DEF = 255;
   localparam int CU_W        = 16;
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register map, indexed by the word address
   localparam logic CSR_IDX_PASSTHROUGH = 1'b0;

   // Characters
   localparam logic [CU_W-1:0] CH_TAB    = 16'h0009;
   localparam logic [CU_W-1:0] CH_LF     = 16'h000A;
   localparam logic [CU_W-1:0] CH_CR     = 16'h000D;
   localparam logic [CU_W-1:0] CH_SPACE  = 16'h0020;
   localparam logic [CU_W-1:0] CH_QUOTE  = 16'h0027;
   localparam logic [CU_W-1:0] CH_STAR   = 16'h002A;
   localparam logic [CU_W-1:0] CH_MINUS  = 16'h002D;
   localparam logic [CU_W-1:0] CH_ZERO   = 16'h0030;
   localparam logic [CU_W-1:0] CH_NINE   = 16'h0039;
   localparam logic [CU_W-1:0] CH_QMARK  = 16'h003F;
   localparam logic [CU_W-1:0] CH_UP_A   = 16'h0041;
   localparam logic [CU_W-1:0] CH_UP_F   = 16'h0046;
   localparam logic [CU_W-1:0] CH_UP_Z   = 16'h005A;
   localparam logic [CU_W-1:0] CH_BSL    = 16'h005C;
   localparam logic [CU_W-1:0] CH_LOW_A  = 16'h0061;
   localparam logic [CU_W-1:0] CH_LOW_B  = 16'h0062;
   localparam logic [CU_W-1:0] CH_LOW_E  = 16'h0065;
   localparam logic [CU_W-1:0] CH_LOW_F  = 16'h0066;
   localparam logic [CU_W-1:0] CH_LOW_I  = 16'h0069;
   localparam logic [CU_W-1:0] CH_LOW_L  = 16'h006C;
   localparam logic [CU_W-1:0] CH_LOW_N  = 16'h006E;
   localparam logic [CU_W-1:0] CH_LOW_P  = 16'h0070;
   localparam logic [CU_W-1:0] CH_LOW_R  = 16'h0072;
   localparam logic [CU_W-1:0] CH_LOW_T  = 16'h0074;
   localparam logic [CU_W-1:0] CH_LOW_U  = 16'h0075;
   localparam logic [CU_W-1:0] CH_LOW_Z  = 16'h007A;
   localparam logic [CU_W-1:0] CH_LBRACE = 16'h007B;
   localparam logic [CU_W-1:0] CH_RBRACE = 16'h007D;

   typedef enum logic [3:0] {
      MODE_TEXT   = 4'd0,
      MODE_BRACE1 = 4'd1,
      MODE_BRACE2 = 4'd2,
      MODE_ESC    = 4'd3,
      MODE_HEX1   = 4'd4,
      MODE_HEX2   = 4'd5,
      MODE_UNI0   = 4'd6,
      MODE_UNINEG = 4'd7,
      MODE_UNIDIG = 4'd8,
      MODE_WLET   = 4'd9,
      MODE_WSIGN  = 4'd10,
      MODE_WDIG   = 4'd11
   } mode_type;

   // Partial match of the control words par, line and tab
   typedef enum logic [3:0] {
      WM_NONE = 4'd0,
      WM_P    = 4'd1,
      WM_PA   = 4'd2,
      WM_PAR  = 4'd3,
      WM_L    = 4'd4,
      WM_LI   = 4'd5,
      WM_LIN  = 4'd6,
      WM_LINE = 4'd7,
      WM_T    = 4'd8,
      WM_TA   = 4'd9,
      WM_TAB  = 4'd10
   } match_type;

   // Results of one item, handed from the parser to the output stage
   typedef struct packed {
      logic [MAX_RESULTS-1:0][CU_W-1:0] units;
      logic [RES_CNT_W-1:0]             count;
      logic                             has_unit;
      logic                             end_flag;
   } bundle_type;

   typedef struct packed {
      logic put_space;
      logic put_char;
      logic pend;
      logic any;
   } emit_type;

   function automatic logic is_digit(input logic [CU_W-1:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_letter(input logic [CU_W-1:0] c);
      return c inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]};
   endfunction

   function automatic logic is_hex(input logic [CU_W-1:0] c);
      return c inside {[CH_ZERO:CH_NINE], [CH_LOW_A:CH_LOW_F], [CH_UP_A:CH_UP_F]};
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [CU_W-1:0] c);
      logic [3:0] r;
      if (is_digit(c)) begin
         r = c[3:0];
      end else begin
         r = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [CU_W-1:0] c);
      return c inside {CH_SPACE, CH_LF, CH_TAB};
   endfunction

   // value * 10 + digit, modulo 2^16
   function automatic logic [CU_W-1:0] mul10_add(input logic [CU_W-1:0] v,
                                                 input logic [CU_W-1:0] c);
      return {v[CU_W-4:0], 3'b000} + {v[CU_W-2:0], 1'b0} + {12'h000, c[3:0]};
   endfunction

   // Collapse whitespace: blanks only arm a pending space once text was seen
   function automatic emit_type emit_char(input logic vld, input logic [CU_W-1:0] c,
                                          input logic pend, input logic any);
      emit_type r;
      r.put_space = 1'b0;
      r.put_char  = 1'b0;
      r.pend      = pend;
      r.any       = any;
      if (vld) begin
         if (is_blank(c)) begin
            if (any) begin
               r.pend = 1'b1;
            end
         end else begin
            r.put_space = pend;
            r.put_char  = 1'b1;
            r.pend      = 1'b0;
            r.any       = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic match_type next_match(input match_type m, input logic [CU_W-1:0] c);
      match_type r;
      r = WM_NONE;
      case (m)
         WM_P:    if (c == CH_LOW_A) r = WM_PA;
         WM_PA:   if (c == CH_LOW_R) r = WM_PAR;
         WM_L:    if (c == CH_LOW_I) r = WM_LI;
         WM_LI:   if (c == CH_LOW_N) r = WM_LIN;
         WM_LIN:  if (c == CH_LOW_E) r = WM_LINE;
         WM_T:    if (c == CH_LOW_A) r = WM_TA;
         WM_TA:   if (c == CH_LOW_B) r = WM_TAB;
         default: r = WM_NONE;
      endcase
      return r;
   endfunction

endpackage

[hdl/rtf_to_plain_text_stream.sv]
// Rich-text to plain-text stream converter.
// Input channel (req_): one UTF-16 code unit of rich text per beat; req_last
// marks the final unit of a text. Result channel (rsp_): one plain-text code
// unit per beat; rsp_has_unit is 0 only on a bare end marker, and
// rsp_end_of_text flags the final result of a text.
// Register passthrough (word 0 of the p* configuration port) passes every unit unchanged;
// change it only while the block is idle.
// Data path: an accepted beat lands in the input register, is parsed
// combinationally and loaded into the result register, which drives its
// first result on the rsp_ port; a stall holds it in the input register.
// Throughput: one item per cycle while the receiver is ready and each item
// yields at most one result; an item yielding two or three results holds
// the result register until its last beat is taken, one beat per cycle on
// the rsp_ port while the receiver is ready. Markup items put no beat on rsp_.
// Reset clears the parser state, the passthrough register and both valid
// flags. When the receiver stalls, the result register holds its beat, the
// input register fills, and req_ready drops until the results drain.
module rtf_to_plain_text_stream
   import rtfp_pkg::*;
#(
   parameter int unsigned MAX_GROUP_DEPTH = MAX_GROUP_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CU_W-1:0]       req_code_unit,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CU_W-1:0]       rsp_text_unit,
   output logic                  rsp_has_unit,
   output logic                  rsp_end_of_text,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic             in_valid_ff;
   logic [CU_W-1:0]  in_unit_ff;
   logic             in_last_ff;
   logic             passthrough_ff;
   logic             step;
   logic             emit_ready;
   logic             csr_wr;
   logic             csr_idx;
   bundle_type       bundle;

   // Input register: advance whenever the parser takes the held beat
   assign step      = in_valid_ff && emit_ready;
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_unit_ff <= req_code_unit;
         in_last_ff <= req_last;
      end
   end

   // Configuration: word address selects the register, byte offset ignored
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign prdata  = (csr_idx == CSR_IDX_PASSTHROUGH) ?
                    {{(CSR_DATA_W-1){1'b0}}, passthrough_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         passthrough_ff <= 1'b0;
      end else if (csr_wr && csr_idx == CSR_IDX_PASSTHROUGH) begin
         passthrough_ff <= pwdata[0];
      end
   end

   // Parse one held unit per cycle, while the result register has room, into a bundle of up to three results
   rtfp_parser #(
      .MAX_GROUP_DEPTH (MAX_GROUP_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .code_unit   (in_unit_ff),
      .last        (in_last_ff),
      .passthrough (passthrough_ff),
      .bundle      (bundle)
   );

   // Result register: drain the bundle one beat per cycle while the receiver is ready
   rtfp_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .bundle      (bundle),
      .ready       (emit_ready),
      .valid       (rsp_valid),
      .take_ready  (rsp_ready),
      .text_unit   (rsp_text_unit),
      .has_unit    (rsp_has_unit),
      .end_of_text (rsp_end_of_text)
   );

`ifndef SYNTHESIS
   // passthrough gives exactly one result per unit
   a_pt_single: assert property (@(posedge clock) disable iff (reset)
      step && passthrough_ff |-> bundle.count == RES_CNT_W'(1))
      else $error("passthrough item did not yield one result");

   // the final unit of a text always yields a result
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      step && in_last_ff |-> bundle.count != '0)
      else $error("final unit yielded no result");

   // a bare end marker closes the text and carries no character
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_unit |-> rsp_end_of_text && rsp_text_unit == '0)
      else $error("bare marker without end flag or with data");

   // a new bundle is only taken when the result register can give it room
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      bundle.count != '0 |-> emit_ready)
      else $error("bundle loaded over pending results");
`endif

endmodule

[hdl/rtfp_parser.sv]
module rtfp_parser
   import rtfp_pkg::*;
#(
   parameter int unsigned MAX_GROUP_DEPTH = MAX_GROUP_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [CU_W-1:0]  code_unit,
   input  logic             last,
   input  logic             passthrough,
   output bundle_type       bundle
);

   localparam int DEPTH_W = $clog2(MAX_GROUP_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_GROUP_DEPTH);

   mode_type           mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               skip_ff, skip_in;
   logic [DEPTH_W-1:0] dlevel_ff, dlevel_in;
   match_type          match_ff, match_in;
   logic [CU_W-1:0]    nval_ff, nval_in;
   logic               nneg_ff, nneg_in;
   logic [3:0]         hexh_ff, hexh_in;
   logic               pend_ff;
   logic               any_ff;

   logic [DEPTH_W-1:0] depth_up, depth_dn;
   logic               close_ends_skip;
   logic [CU_W-1:0]    flush_val;

   logic               esc_v, param_v, plain_v;
   logic               e1_v, e2_v;
   logic [CU_W-1:0]    e1_c, e2_c;
   emit_type           em1, em2;
   logic [3:0]         cand_v;
   logic [3:0][CU_W-1:0] cand_c;
   logic [MAX_RESULTS-1:0][CU_W-1:0] units;
   logic [RES_CNT_W-1:0] n;

   // Group depth moves only through plain text, so work it out from the registers
   assign depth_up        = (depth_ff < DEPTH_MAX) ? depth_ff + 1'b1 : depth_ff;
   assign depth_dn        = (depth_ff != '0) ? depth_ff - 1'b1 : depth_ff;
   assign close_ends_skip = skip_ff && (depth_ff == dlevel_ff);
   assign flush_val       = nneg_ff ? (~nval_ff + 1'b1) : nval_ff;

   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      skip_in   = skip_ff;
      dlevel_in = dlevel_ff;
      match_in  = match_ff;
      nval_in   = nval_ff;
      nneg_in   = nneg_ff;
      hexh_in   = hexh_ff;
      esc_v     = 1'b0;
      param_v   = 1'b0;
      plain_v   = 1'b0;
      e1_v      = 1'b0;
      e1_c      = '0;
      e2_v      = 1'b0;
      e2_c      = '0;

      case (mode_ff)
         MODE_BRACE1: begin
            if (code_unit == CH_BSL) begin
               mode_in = MODE_BRACE2;
            end else begin
               plain_v = 1'b1;
            end
         end
         MODE_BRACE2: begin
            if (code_unit == CH_STAR) begin
               // a nested destination keeps the outer level
               if (!skip_ff) begin
                  skip_in   = 1'b1;
                  dlevel_in = depth_ff;
               end
               mode_in = MODE_TEXT;
            end else begin
               esc_v = 1'b1;
            end
         end
         MODE_ESC: begin
            esc_v = 1'b1;
         end
         MODE_HEX1: begin
            if (is_hex(code_unit)) begin
               hexh_in = hex_nibble(code_unit);
               mode_in = MODE_HEX2;
            end else begin
               plain_v = 1'b1;
            end
         end
         MODE_HEX2: begin
            if (is_hex(code_unit)) begin
               e1_v    = 1'b1;
               e1_c    = {8'h00, hexh_ff, hex_nibble(code_unit)};
               mode_in = MODE_TEXT;
            end else begin
               plain_v = 1'b1;
            end
            hexh_in = '0;
         end
         MODE_UNI0: begin
            if (code_unit == CH_MINUS) begin
               nneg_in = 1'b1;
               mode_in = MODE_UNINEG;
            end else if (is_digit(code_unit)) begin
               nval_in = mul10_add(nval_ff, code_unit);
               mode_in = MODE_UNIDIG;
            end else if (is_letter(code_unit)) begin
               match_in = WM_NONE;
               mode_in  = MODE_WLET;
            end else if (code_unit == CH_SPACE) begin
               mode_in = MODE_TEXT;
            end else begin
               plain_v = 1'b1;
            end
         end
         MODE_UNINEG: begin
            if (is_digit(code_unit)) begin
               nval_in = mul10_add(nval_ff, code_unit);
               mode_in = MODE_UNIDIG;
            end else begin
               nneg_in = 1'b0;
               if (code_unit == CH_SPACE) begin
                  mode_in = MODE_TEXT;
               end else begin
                  plain_v = 1'b1;
               end
            end
         end
         MODE_UNIDIG: begin
            if (is_digit(code_unit)) begin
               nval_in = mul10_add(nval_ff, code_unit);
            end else begin
               e1_v    = 1'b1;
               e1_c    = flush_val;
               nval_in = '0;
               nneg_in = 1'b0;
               if (code_unit == CH_QMARK) begin
                  mode_in = MODE_TEXT;
               end else begin
                  plain_v = 1'b1;
               end
            end
         end
         MODE_WLET: begin
            if (is_letter(code_unit)) begin
               match_in = next_match(match_ff, code_unit);
            end else begin
               if (match_ff inside {WM_PAR, WM_LINE, WM_TAB}) begin
                  e1_v = 1'b1;
                  e1_c = CH_SPACE;
               end
               match_in = WM_NONE;
               param_v  = 1'b1;
            end
         end
         MODE_WSIGN, MODE_WDIG: begin
            if (is_digit(code_unit)) begin
               mode_in = MODE_WDIG;
            end else if (code_unit == CH_SPACE) begin
               mode_in = MODE_TEXT;
            end else begin
               plain_v = 1'b1;
            end
         end
         default: begin
            plain_v = 1'b1;
         end
      endcase

      // escape: the character after a backslash
      if (esc_v) begin
         if (code_unit == CH_QUOTE) begin
            mode_in = MODE_HEX1;
         end else if (code_unit == CH_LOW_U) begin
            nval_in = '0;
            nneg_in = 1'b0;
            mode_in = MODE_UNI0;
         end else if (code_unit inside {CH_BSL, CH_LBRACE, CH_RBRACE}) begin
            e1_v    = 1'b1;
            e1_c    = code_unit;
            mode_in = MODE_TEXT;
         end else if (is_letter(code_unit)) begin
            if (code_unit == CH_LOW_P) begin
               match_in = WM_P;
            end else if (code_unit == CH_LOW_L) begin
               match_in = WM_L;
            end else if (code_unit == CH_LOW_T) begin
               match_in = WM_T;
            end else begin
               match_in = WM_NONE;
            end
            mode_in = MODE_WLET;
         end else begin
            param_v = 1'b1;
         end
      end

      // control word parameter: optional sign, digits, one space
      if (param_v) begin
         if (code_unit == CH_MINUS) begin
            mode_in = MODE_WSIGN;
         end else if (is_digit(code_unit)) begin
            mode_in = MODE_WDIG;
         end else if (code_unit == CH_SPACE) begin
            mode_in = MODE_TEXT;
         end else begin
            plain_v = 1'b1;
         end
      end

      if (plain_v) begin
         mode_in = MODE_TEXT;
         if (code_unit == CH_LBRACE) begin
            depth_in = depth_up;
            if (!skip_ff) begin
               mode_in = MODE_BRACE1;
            end
         end else if (code_unit == CH_RBRACE) begin
            depth_in = depth_dn;
            if (close_ends_skip) begin
               skip_in   = 1'b0;
               dlevel_in = '0;
            end
         end else if (!skip_ff) begin
            if (code_unit == CH_BSL) begin
               mode_in = MODE_ESC;
            end else if (code_unit != CH_CR && code_unit != CH_LF) begin
               e2_v = 1'b1;
               e2_c = code_unit;
            end
         end
      end

      // flush a number still open at the end of text
      if (last && mode_in == MODE_UNIDIG) begin
         e1_v = 1'b1;
         e1_c = nneg_in ? (~nval_in + 1'b1) : nval_in;
      end
   end

   always_comb begin
      em1    = emit_char(e1_v, e1_c, pend_ff, any_ff);
      em2    = emit_char(e2_v, e2_c, em1.pend, em1.any);
      cand_v = {em2.put_char, em2.put_space, em1.put_char, em1.put_space};
      cand_c = {e2_c, CH_SPACE, e1_c, CH_SPACE};
      units  = '0;
      n      = '0;
      // pack the emitted characters in order
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && n < RES_CNT_W'(MAX_RESULTS)) begin
            units[n] = cand_c[i];
            n        = n + 1'b1;
         end
      end

      bundle.units    = units;
      bundle.count    = n;
      bundle.has_unit = 1'b1;
      bundle.end_flag = last;
      if (passthrough) begin
         bundle.units    = '0;
         bundle.units[0] = code_unit;
         bundle.count    = RES_CNT_W'(1);
      end else if (last && n == '0) begin
         bundle.count    = RES_CNT_W'(1);
         bundle.has_unit = 1'b0;
      end
      if (!step) begin
         bundle.count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         mode_ff   <= MODE_TEXT;
         depth_ff  <= '0;
         skip_ff   <= 1'b0;
         dlevel_ff <= '0;
         match_ff  <= WM_NONE;
         nval_ff   <= '0;
         nneg_ff   <= 1'b0;
         hexh_ff   <= '0;
         pend_ff   <= 1'b0;
         any_ff    <= 1'b0;
      end else if (step && !passthrough) begin
         mode_ff   <= mode_in;
         depth_ff  <= depth_in;
         skip_ff   <= skip_in;
         dlevel_ff <= dlevel_in;
         match_ff  <= match_in;
         nval_ff   <= nval_in;
         nneg_ff   <= nneg_in;
         hexh_ff   <= hexh_in;
         pend_ff   <= em2.pend;
         any_ff    <= em2.any;
      end
   end

endmodule

[hdl/rtfp_emitter.sv]
module rtfp_emitter
   import rtfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       bundle,
   output logic             ready,
   output logic             valid,
   input  logic             take_ready,
   output logic [CU_W-1:0]  text_unit,
   output logic             has_unit,
   output logic             end_of_text
);

   bundle_type           bundle_ff;
   logic [RES_CNT_W-1:0] left_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 take;
   logic                 load;

   assign valid = (left_ff != '0);
   assign take  = valid && take_ready;
   // free now, or the final beat of the held bundle leaves this cycle
   assign ready = (left_ff == '0) || (left_ff == RES_CNT_W'(1) && take_ready);
   assign load  = (bundle.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         slot_ff <= '0;
      end else if (load) begin
         left_ff <= bundle.count;
         slot_ff <= '0;
      end else if (take) begin
         left_ff <= left_ff - 1'b1;
         slot_ff <= slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

   assign text_unit   = bundle_ff.units[slot_ff];
   assign has_unit    = bundle_ff.has_unit;
   assign end_of_text = bundle_ff.end_flag && (left_ff == RES_CNT_W'(1));

endmodule
